>>> hdl/rrps_pkg.sv
// Shared types and constants for the round-robin process scheduler.
package rrps_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int SP_W          = 32;
    localparam int SLOT_IO_W     = 4;
    localparam int REQ_W         = 2;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 40;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_BLOCK = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        SLOT_UNUSED  = 2'd0,
        SLOT_READY   = 2'd1,
        SLOT_RUNNING = 2'd2,
        SLOT_BLOCKED = 2'd3
    } t_slot_st;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_LINK,
        S_ADD_CUR,
        S_WALK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic cap;
        logic set_err;
        logic add_start;
        logic add_link_wr;
        logic add_cur_wr;
        logic blk_apply;
        logic tick_start;
        logic walk_step;
        logic walk_end;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        t_req req;
        logic add_ok;
        logic blk_ok;
        logic walk_more;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hdl/round_robin_process_scheduler.sv
// Top level of the round-robin process scheduler.
// Requests enter on the s_axis channel: tuser carries the request type
// (add, timer tick, set blocked mark), tdata the slot, stack pointer and
// blocked flag. Each transaction gives exactly one result transaction on
// m_axis: the stack pointer to resume (ticks only, else zero), the slot
// running afterwards and an ignored-request flag. The idle process
// sits in slot 0; its initial stack pointer is written through i_cfg_we
// and i_cfg_wdata, which the user must do while no request is in
// progress; the block itself does not enforce this. An add passes
// through the decode, link and current steps, a set-blocked or ignored
// request goes from decode to emit, and a tick walks at most MAX_PROCS
// ring links, reading one link per cycle from the link table. One
// request is in flight at a time. The result sits in an output
// register, and the next request is accepted while it waits; a stalled
// receiver holds the block in its emit step only once a second result is
// ready. Synchronous active-low reset leaves only slot 0 linked, ready
// and current, and empties the output register.
module round_robin_process_scheduler #(
    parameter int MAX_PROCS = rrps_pkg::MAX_PROCS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rrps_pkg::SP_W-1:0]        i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // proc_slot[3:0], stack_ptr[35:4], blocked[36], zero pad
    input  logic [rrps_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // req_type[1:0]
    input  logic [rrps_pkg::REQ_W-1:0]       i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // resume_sp[31:0], running_slot[35:32], status[36], zero pad
    output logic [rrps_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import rrps_pkg::*;

    t_ctrl_cmd            w_cmd;
    t_dp_stat             w_stat;
    logic [SP_W-1:0]      w_resume_sp;
    logic [SLOT_IO_W-1:0] w_running_slot;
    logic                 w_status;

    rrps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rrps_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req          (i_s_axis_tuser),
        .i_slot         (i_s_axis_tdata[3:0]),
        .i_sp           (i_s_axis_tdata[35:4]),
        .i_blk          (i_s_axis_tdata[36]),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_resume_sp    (w_resume_sp),
        .o_running_slot (w_running_slot),
        .o_status       (w_status)
    );

    assign o_m_axis_tdata = {3'b000, w_status, w_running_slot, w_resume_sp};

endmodule

>>> hdl/rrps_ctrl.sv
// Control state machine of the round-robin process scheduler.
module rrps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rrps_pkg::t_dp_stat  i_stat,
    output rrps_pkg::t_ctrl_cmd o_cmd
);
    import rrps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.req)
                    REQ_ADD: begin
                        if (i_stat.add_ok) begin
                            o_cmd.add_start = 1'b1;
                            n_state         = S_ADD_LINK;
                        end else begin
                            o_cmd.set_err = 1'b1;
                            n_state       = S_EMIT;
                        end
                    end
                    REQ_TICK: begin
                        o_cmd.tick_start = 1'b1;
                        n_state          = S_WALK;
                    end
                    REQ_BLOCK: begin
                        if (i_stat.blk_ok) begin
                            o_cmd.blk_apply = 1'b1;
                        end else begin
                            o_cmd.set_err = 1'b1;
                        end
                        n_state = S_EMIT;
                    end
                    default: begin
                        o_cmd.set_err = 1'b1;
                        n_state       = S_EMIT;
                    end
                endcase
            end
            S_ADD_LINK: begin
                o_cmd.add_link_wr = 1'b1;
                n_state           = S_ADD_CUR;
            end
            S_ADD_CUR: begin
                o_cmd.add_cur_wr = 1'b1;
                n_state          = S_EMIT;
            end
            S_WALK: begin
                if (i_stat.walk_more) begin
                    o_cmd.walk_step = 1'b1;
                end else begin
                    o_cmd.walk_end = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/rrps_dp.sv
// Datapath of the round-robin process scheduler: slot tables, walk and result register.
module rrps_dp #(
    parameter int MAX_PROCS = rrps_pkg::MAX_PROCS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rrps_pkg::t_ctrl_cmd            i_cmd,
    output rrps_pkg::t_dp_stat             o_stat,
    input  logic                           i_cfg_we,
    input  logic [rrps_pkg::SP_W-1:0]      i_cfg_wdata,
    input  logic [rrps_pkg::REQ_W-1:0]     i_req,
    input  logic [rrps_pkg::SLOT_IO_W-1:0] i_slot,
    input  logic [rrps_pkg::SP_W-1:0]      i_sp,
    input  logic                           i_blk,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [rrps_pkg::SP_W-1:0]      o_resume_sp,
    output logic [rrps_pkg::SLOT_IO_W-1:0] o_running_slot,
    output logic                           o_status
);
    import rrps_pkg::*;

    localparam int SLOT_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int CMP_W  = 8;
    localparam logic [CMP_W-1:0] MAX_CMP   = CMP_W'(MAX_PROCS);
    localparam logic [CNT_W-1:0] MAX_STEPS = CNT_W'(MAX_PROCS);

    // captured request
    t_req                 r_req;
    logic [SLOT_IO_W-1:0] r_slot;
    logic [SP_W-1:0]      r_sp;
    logic                 r_blk;
    logic                 r_err;

    // scheduler state
    t_slot_st             r_status [MAX_PROCS];
    logic [SLOT_W-1:0]    r_cur;
    logic [CNT_W-1:0]     r_steps;
    logic                 r_any_tick;
    logic [SP_W-1:0]      r_idle_sp;
    logic [SLOT_W-1:0]    r_link0;

    // tables
    logic [SLOT_W-1:0]    r_link_mem [MAX_PROCS];
    logic [SP_W-1:0]      r_sp_mem [MAX_PROCS];
    logic [SLOT_W-1:0]    r_link_rd;
    logic [SP_W-1:0]      r_sp_rd;

    // result register
    logic                 r_out_valid;
    logic [SP_W-1:0]      r_out_resume;
    logic [SLOT_IO_W-1:0] r_out_slot;
    logic                 r_out_err;

    logic [SLOT_W-1:0]    w_slot_idx;
    logic                 w_slot_in;
    t_slot_st             w_slot_st;
    t_slot_st             w_cand_st;
    logic [SLOT_W-1:0]    w_link_raddr;
    logic                 w_link_we;
    logic [SLOT_W-1:0]    w_link_waddr;
    logic [SLOT_W-1:0]    w_link_wdata;
    logic                 w_sp_we;
    logic [SLOT_W-1:0]    w_sp_waddr;

    assign w_slot_idx = SLOT_W'(r_slot);
    assign w_slot_in  = (CMP_W'(r_slot) < MAX_CMP);
    assign w_slot_st  = r_status[w_slot_idx];
    assign w_cand_st  = r_status[r_link_rd];

    always_comb begin
        o_stat.req       = r_req;
        o_stat.add_ok    = w_slot_in && (w_slot_st == SLOT_UNUSED);
        o_stat.blk_ok    = w_slot_in && (r_slot != '0) && (w_slot_st != SLOT_UNUSED);
        o_stat.walk_more = (w_cand_st == SLOT_BLOCKED) && (r_link_rd != r_cur) &&
                           (r_steps < MAX_STEPS);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    always_comb begin
        w_link_raddr = i_cmd.walk_step ? r_link_rd : r_cur;
        w_link_we    = i_cmd.add_link_wr || i_cmd.add_cur_wr;
        w_link_waddr = i_cmd.add_link_wr ? w_slot_idx : r_cur;
        w_link_wdata = i_cmd.add_link_wr ? r_link_rd : w_slot_idx;
        w_sp_we      = i_cmd.add_start || i_cmd.tick_start;
        w_sp_waddr   = i_cmd.add_start ? w_slot_idx : r_cur;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req  <= t_req'(i_req);
            r_slot <= i_slot;
            r_sp   <= i_sp;
            r_blk  <= i_blk;
        end
    end

    // link table, slot 0 held in a register so its reset value is known
    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            r_link_mem[w_link_waddr] <= w_link_wdata;
        end
        if (i_cmd.add_start || i_cmd.tick_start || i_cmd.walk_step) begin
            r_link_rd <= (w_link_raddr == '0) ? r_link0 : r_link_mem[w_link_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sp_we) begin
            r_sp_mem[w_sp_waddr] <= r_sp;
        end
        if (i_cmd.walk_end) begin
            r_sp_rd <= (r_link_rd == '0 && !r_any_tick) ? r_idle_sp : r_sp_mem[r_link_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PROCS; i++) begin
                r_status[i] <= (i == 0) ? SLOT_READY : SLOT_UNUSED;
            end
            r_cur       <= '0;
            r_steps     <= '0;
            r_any_tick  <= 1'b0;
            r_idle_sp   <= '0;
            r_link0     <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_idle_sp <= i_cfg_wdata;
            end
            if (i_cmd.cap) begin
                r_err <= 1'b0;
            end
            if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
            if (w_link_we && w_link_waddr == '0) begin
                r_link0 <= w_link_wdata;
            end
            if (i_cmd.add_start) begin
                r_status[w_slot_idx] <= SLOT_READY;
            end
            if (i_cmd.blk_apply) begin
                if (r_blk) begin
                    r_status[w_slot_idx] <= SLOT_BLOCKED;
                end else if (w_slot_st == SLOT_BLOCKED) begin
                    r_status[w_slot_idx] <= SLOT_READY;
                end
            end
            if (i_cmd.tick_start) begin
                r_any_tick <= 1'b1;
                r_steps    <= CNT_W'(1);
                if (r_status[r_cur] == SLOT_RUNNING) begin
                    r_status[r_cur] <= SLOT_READY;
                end
            end
            if (i_cmd.walk_step) begin
                r_steps <= r_steps + CNT_W'(1);
            end
            if (i_cmd.walk_end) begin
                r_status[r_link_rd] <= SLOT_RUNNING;
                r_cur               <= r_link_rd;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_resume <= (r_req == REQ_TICK) ? r_sp_rd : '0;
            r_out_slot   <= SLOT_IO_W'(r_cur);
            r_out_err    <= r_err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_resume_sp    = r_out_resume;
    assign o_running_slot = r_out_slot;
    assign o_status       = r_out_err;

endmodule
